### src/scd_pkg.sv
// Shared constants and types of the stream chunk deframer.
// No dependencies; the core and the checker refer to it by scoped names.
package scd_pkg;

    // Header framing bytes and the payload clear mask
    localparam logic [7:0] MARK       = 8'h5a;
    localparam logic [7:0] SKIP_MARK  = 8'h62;
    localparam logic [7:0] MSG_MARK   = 8'h58;
    localparam logic [7:0] CLEAR_MASK = 8'hfe;

    localparam logic [7:0] PERIOD_RESET   = 8'd43;
    localparam int         MAX_PACKET_DEF = 1024;
    localparam int         MIN_LEN        = 6;

    // Header and packet layout
    localparam int HDR_LEN    = 8;
    localparam int BURST_LEN  = 5;
    localparam int POS_STREAM = 5;
    localparam int POS_CLEAR  = 10;
    localparam int POS_SAT    = 11;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        KIND_PACKET       = 3'd0,
        KIND_KEEPALIVE    = 3'd1,
        KIND_BAD_MARKER   = 3'd2,
        KIND_OFF_MISMATCH = 3'd3,
        KIND_BAD_LENGTH   = 3'd4,
        KIND_HALT         = 3'd5
    } t_kind;

endpackage

### src/scd_byte_if.sv
// Input channel of the deframer: one received byte per request.
// Depends on nothing.
interface scd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### src/scd_result_if.sv
// Result channel of the deframer: kind, data and last per request.
// Depends on nothing.
interface scd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

### src/stream_chunk_deframer_core.sv
// A result is written into the result queue when the byte that causes it is accepted and
// shows on o_out once the records queued ahead of it have left.
// Throughput: one byte accepted per cycle while the 4-record result queue has room;
// one result leaves per cycle while o_out is ready, and an accepted header expands to 5 results.
// Reset (i_rst_n low, synchronous): empty queue, collect-header phase, all counters zero,
// keepalive period 43.
// Depends on scd_pkg, scd_byte_if and scd_result_if.
module stream_chunk_deframer_core #(
    parameter int MAX_PACKET = scd_pkg::MAX_PACKET_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    scd_byte_if.sink            i_in,
    scd_result_if.source        o_out
);

    localparam int LEN_W = $clog2(MAX_PACKET + 1);
    localparam int QD    = scd_pkg::QUEUE_DEPTH;
    localparam int QA    = $clog2(QD);
    localparam int QC    = $clog2(QD + 1);

    typedef enum logic [3:0] {
        PH_COLLECT = 4'b0001,
        PH_RESYNC  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_HALT    = 4'b1000
    } t_phase;

    // One queue record is what one input byte causes: a single result, or the
    // five-byte rebuilt header (zero, zero, length high, length low, zero).
    typedef struct packed {
        logic          burst;
        scd_pkg::t_kind kind;
        logic          last;
        logic [15:0]   word;
    } t_rec;

    // Deframer state
    logic [7:0]       r_win [scd_pkg::HDR_LEN];
    logic [7:0]       n_win [scd_pkg::HDR_LEN];
    t_phase           r_phase, n_phase;
    logic [2:0]       r_hcount, n_hcount;
    logic             r_skip_done, n_skip_done;
    logic [LEN_W-1:0] r_remain, n_remain;
    logic [3:0]       r_pos, n_pos;
    logic [15:0]      r_first_idx, n_first_idx;
    logic [15:0]      r_maj_a, n_maj_a, r_maj_b, n_maj_b;
    logic [7:0]       r_min_a, n_min_a, r_min_b, n_min_b;
    logic [7:0]       r_pkt_phase, n_pkt_phase;
    logic [7:0]       r_period;

    // Result queue
    t_rec             r_q [QD];
    logic [QA-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QC-1:0]    r_q_count;
    logic [2:0]       r_beat;

    logic             in_fire, out_fire, push, head_done;
    t_rec             push_rec, head;

    function automatic t_rec status_rec(scd_pkg::t_kind k);
        t_rec r;
        r.burst = 1'b0;
        r.kind  = k;
        r.last  = 1'b1;
        r.word  = 16'd0;
        return r;
    endfunction

    assign i_in.ready = (r_q_count != QC'(QD));
    assign in_fire    = i_in.valid && i_in.ready;

    // Per-byte step: all of the parsing for one request is done here
    always_comb begin
        logic [7:0]  b;
        logic [7:0]  hdr [scd_pkg::HDR_LEN];
        logic        do_check;
        logic [15:0] off1, off2;
        logic        hit_a, hit_b;
        logic        stream;
        logic [7:0]  d;
        logic [LEN_W-1:0] rem_dec;
        logic        fin;
        logic [8:0]  next_pp;

        b        = i_in.rx_byte;
        hdr      = r_win;
        do_check = 1'b0;
        off1     = 16'd0;
        off2     = 16'd0;
        hit_a    = 1'b0;
        hit_b    = 1'b0;
        stream   = 1'b0;
        d        = 8'd0;
        rem_dec  = r_remain;
        fin      = 1'b0;
        next_pp  = 9'd0;

        n_win       = r_win;
        n_phase     = r_phase;
        n_hcount    = r_hcount;
        n_skip_done = r_skip_done;
        n_remain    = r_remain;
        n_pos       = r_pos;
        n_first_idx = r_first_idx;
        n_maj_a     = r_maj_a;
        n_min_a     = r_min_a;
        n_maj_b     = r_maj_b;
        n_min_b     = r_min_b;
        n_pkt_phase = r_pkt_phase;
        push        = 1'b0;
        push_rec    = '0;

        if (in_fire) begin
            case (r_phase)
                PH_COLLECT: begin
                    // keepalive goes out ahead of the first byte of an attempt
                    if (r_hcount == 3'd0 && !r_skip_done && r_pkt_phase == 8'd0) begin
                        push     = 1'b1;
                        push_rec = status_rec(scd_pkg::KIND_KEEPALIVE);
                    end
                    hdr[r_hcount] = b;
                    n_win         = hdr;
                    n_hcount      = r_hcount + 3'd1;
                    if (r_hcount == 3'(scd_pkg::HDR_LEN - 1)) begin
                        if (!r_skip_done && hdr[0] == scd_pkg::SKIP_MARK) begin
                            n_skip_done = 1'b1;
                        end else if (hdr[0] == scd_pkg::MSG_MARK) begin
                            n_phase  = PH_HALT;
                            push     = 1'b1;
                            push_rec = status_rec(scd_pkg::KIND_HALT);
                        end else if (hdr[0] != scd_pkg::MARK) begin
                            n_phase = PH_RESYNC;
                        end else begin
                            do_check = 1'b1;
                        end
                    end
                end
                PH_RESYNC: begin
                    // slide the window one byte until it opens with the marker
                    for (int i = 0; i < scd_pkg::HDR_LEN - 1; i++) begin
                        hdr[i] = r_win[i + 1];
                    end
                    hdr[scd_pkg::HDR_LEN - 1] = b;
                    n_win = hdr;
                    if (hdr[0] == scd_pkg::MARK) begin
                        do_check = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_pos == 4'(scd_pkg::POS_STREAM)) begin
                        // pick the stream number from the two indices
                        hit_a = (r_first_idx == r_maj_a);
                        hit_b = (r_first_idx == r_maj_b);
                        if (hit_a != hit_b) begin
                            if (hit_a) begin
                                n_maj_a = r_maj_a + 16'd1;
                                n_min_a = b + 8'd1;
                                stream  = 1'b0;
                            end else begin
                                n_maj_b = r_maj_b + 16'd1;
                                n_min_b = b + 8'd1;
                                stream  = 1'b1;
                            end
                        end else if (b == r_min_a && b != r_min_b) begin
                            n_maj_a = r_first_idx + 16'd1;
                            n_min_a = r_min_a + 8'd1;
                            stream  = 1'b0;
                        end else if (b == r_min_b && b != r_min_a) begin
                            n_maj_b = r_first_idx + 16'd1;
                            n_min_b = r_min_b + 8'd1;
                            stream  = 1'b1;
                        end else begin
                            n_maj_a = r_first_idx + 16'd1;
                            n_min_a = b + 8'd1;
                            stream  = 1'b0;
                        end
                        d = {7'd0, stream};
                    end else if (r_pos == 4'(scd_pkg::POS_CLEAR)) begin
                        d = b & scd_pkg::CLEAR_MASK;
                    end else begin
                        d = b;
                    end
                    // positions past the cleared byte all behave alike: saturate
                    if (r_pos != 4'(scd_pkg::POS_SAT)) begin
                        n_pos = r_pos + 4'd1;
                    end
                    if (r_remain != '0) begin
                        rem_dec = r_remain - LEN_W'(1);
                    end
                    n_remain      = rem_dec;
                    fin           = (rem_dec == '0);
                    push          = 1'b1;
                    push_rec.kind = scd_pkg::KIND_PACKET;
                    push_rec.last = fin;
                    push_rec.word = {8'd0, d};
                    if (fin) begin
                        next_pp     = {1'b0, r_pkt_phase} + 9'd1;
                        n_pkt_phase = (next_pp >= {1'b0, r_period}) ? 8'd0 : next_pp[7:0];
                        n_phase     = PH_COLLECT;
                        n_hcount    = 3'd0;
                        n_skip_done = 1'b0;
                    end
                end
                default: begin
                    // halted: drop every byte
                end
            endcase

            if (do_check) begin
                off1 = {hdr[1], hdr[2]};
                off2 = {hdr[3], hdr[4]};
                push = 1'b1;
                if (hdr[scd_pkg::HDR_LEN - 1] != scd_pkg::MARK ||
                    off1 != off2 ||
                    off1 < 16'(scd_pkg::MIN_LEN) ||
                    {1'b0, off1} > 17'(MAX_PACKET)) begin
                    if (hdr[scd_pkg::HDR_LEN - 1] != scd_pkg::MARK) begin
                        push_rec = status_rec(scd_pkg::KIND_BAD_MARKER);
                    end else if (off1 != off2) begin
                        push_rec = status_rec(scd_pkg::KIND_OFF_MISMATCH);
                    end else begin
                        push_rec = status_rec(scd_pkg::KIND_BAD_LENGTH);
                    end
                    n_phase     = PH_COLLECT;
                    n_hcount    = 3'd0;
                    n_skip_done = 1'b0;
                end else begin
                    n_first_idx    = {hdr[5], hdr[6]};
                    push_rec.burst = 1'b1;
                    push_rec.kind  = scd_pkg::KIND_PACKET;
                    push_rec.last  = 1'b0;
                    push_rec.word  = off1;
                    n_remain       = LEN_W'(off1 - 16'd5);
                    n_pos          = 4'(scd_pkg::POS_STREAM);
                    n_phase        = PH_PAYLOAD;
                end
            end
        end
    end

    // Hold the deframer state; take configuration writes at any time outside reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < scd_pkg::HDR_LEN; i++) begin
                r_win[i] <= 8'd0;
            end
            r_phase     <= PH_COLLECT;
            r_hcount    <= 3'd0;
            r_skip_done <= 1'b0;
            r_remain    <= '0;
            r_pos       <= 4'd0;
            r_first_idx <= 16'd0;
            r_maj_a     <= 16'd0;
            r_min_a     <= 8'd0;
            r_maj_b     <= 16'd0;
            r_min_b     <= 8'd0;
            r_pkt_phase <= 8'd0;
            r_period    <= scd_pkg::PERIOD_RESET;
        end else begin
            r_win       <= n_win;
            r_phase     <= n_phase;
            r_hcount    <= n_hcount;
            r_skip_done <= n_skip_done;
            r_remain    <= n_remain;
            r_pos       <= n_pos;
            r_first_idx <= n_first_idx;
            r_maj_a     <= n_maj_a;
            r_min_a     <= n_min_a;
            r_maj_b     <= n_maj_b;
            r_min_b     <= n_min_b;
            r_pkt_phase <= n_pkt_phase;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    // Result queue: at most one record written per accepted byte, read from the head
    assign head      = r_q[r_rd_ptr];
    assign out_fire  = o_out.valid && o_out.ready;
    assign head_done = !head.burst || (r_beat == 3'(scd_pkg::BURST_LEN - 1));

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_q_count <= '0;
            r_beat    <= 3'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QA'(QD - 1)) ? '0 : r_wr_ptr + QA'(1);
            end
            if (out_fire) begin
                if (head_done) begin
                    r_beat   <= 3'd0;
                    r_rd_ptr <= (r_rd_ptr == QA'(QD - 1)) ? '0 : r_rd_ptr + QA'(1);
                end else begin
                    r_beat <= r_beat + 3'd1;
                end
            end
            r_q_count <= r_q_count + QC'(push) - QC'(out_fire && head_done);
        end
    end

    // Expand the head record: a header burst carries the length in beats 2 and 3
    always_comb begin
        o_out.valid = (r_q_count != '0);
        o_out.kind  = head.kind;
        o_out.last  = head.last;
        o_out.data  = head.word[7:0];
        if (head.burst) begin
            o_out.kind = scd_pkg::KIND_PACKET;
            o_out.last = 1'b0;
            case (r_beat)
                3'd2:    o_out.data = head.word[15:8];
                3'd3:    o_out.data = head.word[7:0];
                default: o_out.data = 8'd0;
            endcase
        end
    end

endmodule

### src/scd_checker.sv
// Port-level checks on the deframer result channel, bound to the top level.
// Depends on scd_pkg and stream_chunk_deframer_core.
module scd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_kind,
    input logic [7:0] i_out_data,
    input logic       i_out_last
);

    logic r_prev_keep;

    // Remember whether the last result taken was a keepalive request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keep <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_prev_keep <= (i_out_kind == scd_pkg::KIND_KEEPALIVE);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) &&
        $stable(i_out_data) && $stable(i_out_last))
        else $error("stalled result changed");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != scd_pkg::KIND_PACKET |-> i_out_last && i_out_data == 8'd0)
        else $error("status result without last or with data");

    a_halt_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_kind == scd_pkg::KIND_HALT |=> !i_out_valid)
        else $error("result after server message halt");

    a_keep_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && r_prev_keep |-> i_out_kind != scd_pkg::KIND_KEEPALIVE)
        else $error("two keepalive requests in a row");

endmodule

bind stream_chunk_deframer_core scd_checker u_scd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_data  (o_out.data),
    .i_out_last  (o_out.last)
);
